>>> rtl/core/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared widths, ASCII codes and status types for the integer formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 5;
  localparam int PAD_W   = 6;
  localparam int CHAR_W  = 7;
  localparam int LEN_W   = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CH_PLUS    = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] DEC_LIMIT  = 7'd10;

  // Status of the serial divider toward the sequencer
  typedef struct packed {
    logic               done;   // one-cycle pulse, quotient and digit valid
    logic [DIGIT_W-1:0] digit;  // remainder of the last division
    logic               more;   // quotient is nonzero
  } div_status_t;

  // Map one digit to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (dx < DEC_LIMIT) begin
      return CH_ZERO + dx;
    end else begin
      return (upper ? CH_UPPER_A : CH_LOWER_A) + dx - DEC_LIMIT;
    end
  endfunction

endpackage

>>> rtl/core/itoa_serial_div.sv
// ----------------------------------------------------------------------------
// itoa_serial_div
// Restoring divider by the radix, one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module itoa_serial_div #(
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [VALUE_BITS-1:0]            dividend,
  input  logic [itoa_pkg::RADIX_W-1:0]     radix,
  output logic [VALUE_BITS-1:0]            quotient,
  output itoa_pkg::div_status_t            status
);

  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0]        q_r;
  logic [itoa_pkg::DIGIT_W-1:0] rem_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic                         nz_r;

  logic [itoa_pkg::RADIX_W-1:0] trial;
  logic [itoa_pkg::RADIX_W-1:0] trial_sub;
  logic                         q_bit;
  logic                         last_bit;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial     = {rem_r, q_r[VALUE_BITS-1]};
  assign q_bit     = (trial >= radix);
  assign trial_sub = trial - radix;
  assign last_bit  = (cnt_r == CNT_W'(VALUE_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last_bit;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        nz_r   <= 1'b0;
      end else if (busy_r) begin
        q_r   <= {q_r[VALUE_BITS-2:0], q_bit};
        rem_r <= q_bit ? trial_sub[itoa_pkg::DIGIT_W-1:0] : trial[itoa_pkg::DIGIT_W-1:0];
        nz_r  <= nz_r | q_bit;
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quotient     = q_r;
  assign status.done  = done_r;
  assign status.digit = rem_r;
  assign status.more  = nz_r;

endmodule

>>> rtl/core/itoa_digit_stack.sv
// ----------------------------------------------------------------------------
// itoa_digit_stack
// Shift-register stack of digits: push at the head, pop from the head.
// ----------------------------------------------------------------------------
module itoa_digit_stack #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         push,
  input  logic                         pop,
  input  logic [itoa_pkg::DIGIT_W-1:0] push_digit,
  output logic [itoa_pkg::DIGIT_W-1:0] top_digit
);

  logic [itoa_pkg::DIGIT_W-1:0] slot_r [DEPTH];

  // Shift up on push, shift down on pop
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[0] <= push_digit;
      for (int i = 1; i < DEPTH; i++) begin
        slot_r[i] <= slot_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  assign top_digit = slot_r[0];

endmodule

>>> rtl/core/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer as ASCII text: sign, padding, digits MSB first.
// ----------------------------------------------------------------------------
//
//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------------
//  input    | in        | in_valid/in_stall, value, radix and format flags
//  result   | out       | out_valid/out_stall, character, is_last, total_length
//
//  Each digit comes from one run of the bit-serial divider, which is restarted
//  on the quotient until it runs out or the digit slots are full; the sign,
//  padding and digit characters follow. Output stalls stretch only the
//  character phase.
//  Reset is synchronous and active low; the input is refused until the
//  last character of the current number has been loaded for transfer.
//
module integer_to_ascii_formatter_unit #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_SLOTS = 16,
  parameter int MAX_PAD     = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VALUE_BITS-1:0]         in_value,
  input  logic [itoa_pkg::RADIX_W-1:0]  in_radix,
  input  logic                          in_is_unsigned,
  input  logic [itoa_pkg::PAD_W-1:0]    in_pad_width,
  input  logic                          in_pad_with_zeros,
  input  logic                          in_force_plus,
  input  logic                          in_space_for_plus,
  input  logic                          in_upper_case,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itoa_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_is_last,
  output logic [itoa_pkg::LEN_W-1:0]    out_total_length
);

  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int CMP_W = (CNT_W > itoa_pkg::PAD_W) ? CNT_W : itoa_pkg::PAD_W;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SIGN, S_PAD, S_DIGITS} state_t;

  state_t                        state_r, state_nxt;
  logic [itoa_pkg::RADIX_W-1:0]  radix_r;
  logic [itoa_pkg::PAD_W-1:0]    pad_r;
  logic [itoa_pkg::PAD_W-1:0]    pad_rem_r;
  logic                          zero_pad_r;
  logic                          upper_r;
  logic                          has_sign_r;
  logic [itoa_pkg::CHAR_W-1:0]   sign_char_r;
  logic [CNT_W-1:0]              digit_count_r;
  logic [itoa_pkg::LEN_W-1:0]    len_r;

  logic                          out_valid_r;
  logic [itoa_pkg::CHAR_W-1:0]   out_char_r;
  logic                          out_last_r;
  logic [itoa_pkg::LEN_W-1:0]    out_len_r;

  logic                          accept;
  logic                          adv;
  logic                          negative;
  logic [VALUE_BITS-1:0]         abs_value;
  logic [itoa_pkg::RADIX_W-1:0]  radix_sat;
  logic [itoa_pkg::PAD_W-1:0]    pad_sat;
  logic [CNT_W-1:0]              count_inc;
  logic                          convert_more;
  logic                          div_start;
  logic [VALUE_BITS-1:0]         div_dividend;
  logic [VALUE_BITS-1:0]         div_quotient;
  itoa_pkg::div_status_t         div_st;
  logic [itoa_pkg::DIGIT_W-1:0]  stack_top;
  logic                          emit;
  logic                          emit_last;
  logic [itoa_pkg::CHAR_W-1:0]   emit_char;
  logic [CMP_W-1:0]              pad_ext;
  logic [CMP_W-1:0]              cnt_ext;
  logic [CMP_W-1:0]              pad_diff;

  // Input handshake and operand conditioning
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign negative  = in_value[VALUE_BITS-1];
  assign abs_value = (!in_is_unsigned && negative) ? (~in_value + 1'b1) : in_value;

  always_comb begin
    radix_sat = in_radix;
    if (in_radix < itoa_pkg::RADIX_MIN) begin
      radix_sat = itoa_pkg::RADIX_MIN;
    end else if (in_radix > itoa_pkg::RADIX_MAX) begin
      radix_sat = itoa_pkg::RADIX_MAX;
    end
  end

  assign pad_sat = (in_pad_width > itoa_pkg::PAD_W'(MAX_PAD)) ?
                   itoa_pkg::PAD_W'(MAX_PAD) : in_pad_width;

  // Restart the divider on the quotient until it runs out or slots are full
  assign count_inc    = digit_count_r + 1'b1;
  assign convert_more = div_st.more && (count_inc < CNT_W'(DIGIT_SLOTS));
  assign div_start    = accept || ((state_r == S_DIV) && div_st.done && convert_more);
  assign div_dividend = accept ? abs_value : div_quotient;

  itoa_serial_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (accept ? radix_sat : radix_r),
    .quotient (div_quotient),
    .status   (div_st)
  );

  itoa_digit_stack #(
    .DEPTH (DIGIT_SLOTS)
  ) u_stack (
    .clk        (clk),
    .push       ((state_r == S_DIV) && div_st.done),
    .pop        (emit && (state_r == S_DIGITS)),
    .push_digit (div_st.digit),
    .top_digit  (stack_top)
  );

  // Pad characters still needed once the digit count is known
  assign pad_ext  = CMP_W'(pad_r);
  assign cnt_ext  = CMP_W'(digit_count_r);
  assign pad_diff = (pad_ext > cnt_ext) ? (pad_ext - cnt_ext) : '0;

  // Character selection and next state
  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = itoa_pkg::CH_SPACE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_st.done && !convert_more) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        emit_char = sign_char_r;
        if (!has_sign_r) begin
          state_nxt = S_PAD;
        end else if (adv) begin
          emit      = 1'b1;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        emit_char = zero_pad_r ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
        if (pad_rem_r == '0) begin
          state_nxt = S_DIGITS;
        end else if (adv) begin
          emit = 1'b1;
        end
      end
      S_DIGITS: begin
        emit_char = itoa_pkg::digit_char(stack_top, upper_r);
        emit_last = (digit_count_r == CNT_W'(1));
        if (adv) begin
          emit = 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, working registers and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        radix_r       <= radix_sat;
        pad_r         <= pad_sat;
        zero_pad_r    <= in_pad_with_zeros;
        upper_r       <= in_upper_case;
        has_sign_r    <= !in_is_unsigned && (negative || in_force_plus || in_space_for_plus);
        sign_char_r   <= negative ? itoa_pkg::CH_MINUS :
                         (in_force_plus ? itoa_pkg::CH_PLUS : itoa_pkg::CH_SPACE);
        digit_count_r <= '0;
        len_r         <= '0;
      end

      if ((state_r == S_DIV) && div_st.done) begin
        digit_count_r <= count_inc;
      end

      if (state_r == S_SIGN) begin
        pad_rem_r <= pad_diff[itoa_pkg::PAD_W-1:0];
      end

      if (emit) begin
        len_r <= len_r + 1'b1;
        if (state_r == S_PAD) begin
          pad_rem_r <= pad_rem_r - 1'b1;
        end
        if (state_r == S_DIGITS) begin
          digit_count_r <= digit_count_r - 1'b1;
        end
      end

      if (adv) begin
        out_valid_r <= emit;
        if (emit) begin
          out_char_r <= emit_char;
          out_last_r <= emit_last;
          out_len_r  <= emit_last ? (len_r + 1'b1) : '0;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_character    = out_char_r;
  assign out_is_last      = out_last_r;
  assign out_total_length = out_len_r;

`ifndef SYNTHESIS
  // Taking an item makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not refused after a transfer");

  // The divider only finishes while a conversion is in progress
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == S_DIV))
    else $error("divider finished outside conversion");

  // Digit phase always has a digit left on the stack
  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGITS) |-> (digit_count_r != '0))
    else $error("digit phase with empty stack");

  // Length is reported on the last character only
  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_len_r != '0)))
    else $error("total length out of place");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_ascii_formatter_unit: a directed set of
// corner numbers followed by random numbers with random flags, both channels
// throttled at random, each character checked against a local text builder.
// ----------------------------------------------------------------------------
module tb;

  localparam int VALUE_BITS  = 32;
  localparam int DIGIT_SLOTS = 16;
  localparam int MAX_PAD     = 63;
  localparam int RANDOM_NUMS = 305;
  localparam int IDLE_PCT    = 14;
  localparam int CALM_START  = 20000;
  localparam int CALM_STOP   = 40000;
  localparam int TAIL_CYCLES = 500;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic [VALUE_BITS-1:0]        value;
    logic [itoa_pkg::RADIX_W-1:0] radix;
    logic                         is_unsigned;
    logic [itoa_pkg::PAD_W-1:0]   pad_width;
    logic                         pad_with_zeros;
    logic                         force_plus;
    logic                         space_for_plus;
    logic                         upper_case;
    logic                         wait_drain;  // hold off until all text has come back
  } num_item_t;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] character;
    logic                        is_last;
    logic [itoa_pkg::LEN_W-1:0]  total_length;
  } text_char_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [VALUE_BITS-1:0]        in_value;
  logic [itoa_pkg::RADIX_W-1:0] in_radix;
  logic                         in_is_unsigned;
  logic [itoa_pkg::PAD_W-1:0]   in_pad_width;
  logic                         in_pad_with_zeros;
  logic                         in_force_plus;
  logic                         in_space_for_plus;
  logic                         in_upper_case;
  logic                         out_valid;
  logic                         out_stall;
  logic [itoa_pkg::CHAR_W-1:0]  out_character;
  logic                         out_is_last;
  logic [itoa_pkg::LEN_W-1:0]   out_total_length;

  num_item_t  pending_nums[$];
  text_char_t expected_text[$];
  num_item_t  cur_num;
  logic       num_taken;
  int         cycle_cnt;
  int         errors;
  int         nums_taken;
  int         chars_checked;
  int         longest_text;
  logic       calm;

  integer_to_ascii_formatter_unit #(
    .VALUE_BITS (VALUE_BITS),
    .DIGIT_SLOTS(DIGIT_SLOTS),
    .MAX_PAD    (MAX_PAD)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_radix         (in_radix),
    .in_is_unsigned   (in_is_unsigned),
    .in_pad_width     (in_pad_width),
    .in_pad_with_zeros(in_pad_with_zeros),
    .in_force_plus    (in_force_plus),
    .in_space_for_plus(in_space_for_plus),
    .in_upper_case    (in_upper_case),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_character    (out_character),
    .out_is_last      (out_is_last),
    .out_total_length (out_total_length)
  );

  // Toggle the clock every half period
  always #4 clk = ~clk;

  assign calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_STOP);

  // Build the text of one number and queue its characters
  function automatic void format_number(input num_item_t it);
    logic [VALUE_BITS-1:0]        mag;
    logic [VALUE_BITS-1:0]        base;
    logic [itoa_pkg::DIGIT_W-1:0] digs [0:DIGIT_SLOTS-1];
    logic [itoa_pkg::CHAR_W-1:0]  txt [0:MAX_PAD];
    logic [itoa_pkg::CHAR_W-1:0]  c;
    text_char_t                   e;
    int                           nd;
    int                           npad;
    int                           padw;
    int                           n;
    int                           k;
    base = VALUE_BITS'(it.radix);
    if (base < VALUE_BITS'(itoa_pkg::RADIX_MIN)) base = VALUE_BITS'(itoa_pkg::RADIX_MIN);
    if (base > VALUE_BITS'(itoa_pkg::RADIX_MAX)) base = VALUE_BITS'(itoa_pkg::RADIX_MAX);
    padw = int'(it.pad_width);
    if (padw > MAX_PAD) padw = MAX_PAD;
    // Negate signed negatives; the most negative value stays as is
    if (!it.is_unsigned && it.value[VALUE_BITS-1]) begin
      mag = ~it.value + 1'b1;
    end else begin
      mag = it.value;
    end
    // Collect digits, least significant first
    nd = 0;
    do begin
      digs[nd] = itoa_pkg::DIGIT_W'(mag % base);
      mag = mag / base;
      nd = nd + 1;
    end while (mag != 0 && nd < DIGIT_SLOTS);
    // Sign
    n = 0;
    if (!it.is_unsigned) begin
      if (it.value[VALUE_BITS-1]) begin
        txt[n] = itoa_pkg::CH_MINUS;
        n = n + 1;
      end else if (it.force_plus) begin
        txt[n] = itoa_pkg::CH_PLUS;
        n = n + 1;
      end else if (it.space_for_plus) begin
        txt[n] = itoa_pkg::CH_SPACE;
        n = n + 1;
      end
    end
    // Padding up to the requested digit width
    npad = (padw > nd) ? padw - nd : 0;
    for (k = 0; k < npad; k++) begin
      txt[n] = it.pad_with_zeros ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
      n = n + 1;
    end
    // Digits, most significant first
    for (k = nd - 1; k >= 0; k--) begin
      if (digs[k] < 10) begin
        c = itoa_pkg::CH_ZERO + {3'b000, digs[k]};
      end else begin
        c = (it.upper_case ? itoa_pkg::CH_UPPER_A : itoa_pkg::CH_LOWER_A) +
            {3'b000, digs[k]} - 7'd10;
      end
      txt[n] = c;
      n = n + 1;
    end
    for (k = 0; k < n; k++) begin
      e.character    = txt[k];
      e.is_last      = (k == n - 1);
      e.total_length = (k == n - 1) ? n[itoa_pkg::LEN_W-1:0] : '0;
      expected_text.push_back(e);
    end
  endfunction

  function automatic num_item_t make_num(input logic [VALUE_BITS-1:0] v,
                                         input logic [itoa_pkg::RADIX_W-1:0] r,
                                         input logic uns,
                                         input logic [itoa_pkg::PAD_W-1:0] pw,
                                         input logic zeros,
                                         input logic plus,
                                         input logic sp,
                                         input logic up);
    num_item_t it;
    it.value          = v;
    it.radix          = r;
    it.is_unsigned    = uns;
    it.pad_width      = pw;
    it.pad_with_zeros = zeros;
    it.force_plus     = plus;
    it.space_for_plus = sp;
    it.upper_case     = up;
    it.wait_drain     = 1'b0;
    return it;
  endfunction

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d characters still expected", $time, expected_text.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Record an input transfer and queue its text
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      format_number(cur_num);
      nums_taken = nums_taken + 1;
      num_taken = 1'b1;
    end
  end

  // Drive the next number after a transfer, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || num_taken) begin
      num_taken = 1'b0;
      if (pending_nums.size() == 0 ||
          (pending_nums[0].wait_drain && expected_text.size() != 0) ||
          (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
        in_valid <= 1'b0;
      end else begin
        cur_num = pending_nums.pop_front();
        in_valid          <= 1'b1;
        in_value          <= cur_num.value;
        in_radix          <= cur_num.radix;
        in_is_unsigned    <= cur_num.is_unsigned;
        in_pad_width      <= cur_num.pad_width;
        in_pad_with_zeros <= cur_num.pad_with_zeros;
        in_force_plus     <= cur_num.force_plus;
        in_space_for_plus <= cur_num.space_for_plus;
        in_upper_case     <= cur_num.upper_case;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Check each result transfer against the oldest expected character
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h last %b len %0d",
                 $time, out_character, out_is_last, out_total_length);
        errors = errors + 1;
      end else begin
        want = expected_text.pop_front();
        chars_checked = chars_checked + 1;
        if (out_is_last && out_total_length > longest_text) longest_text = out_total_length;
        if (out_character !== want.character) begin
          $display("%0t: character mismatch: expected %h actual %h",
                   $time, want.character, out_character);
          errors = errors + 1;
        end
        if (out_is_last !== want.is_last) begin
          $display("%0t: is_last mismatch: expected %b actual %b",
                   $time, want.is_last, out_is_last);
          errors = errors + 1;
        end
        if (out_total_length !== want.total_length) begin
          $display("%0t: total_length mismatch: expected %0d actual %0d",
                   $time, want.total_length, out_total_length);
          errors = errors + 1;
        end
      end
    end
  end

  // Fill the stimulus queue, run reset and wait for the end
  initial begin : stimulus
    num_item_t it;
    int        i;
    int        pick;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_radix = '0;
    in_is_unsigned = 1'b0;
    in_pad_width = '0;
    in_pad_with_zeros = 1'b0;
    in_force_plus = 1'b0;
    in_space_for_plus = 1'b0;
    in_upper_case = 1'b0;
    out_stall = 1'b0;
    num_taken = 1'b0;
    cur_num = '0;
    cycle_cnt = 0;
    errors = 0;
    nums_taken = 0;
    chars_checked = 0;
    longest_text = 0;

    // Directed corners: zero, extremes, sign rules, padding, radix clamping
    pending_nums.push_back(make_num(32'd0, 5'd10, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'hFFFFFFFF, 5'd16, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1));
    pending_nums.push_back(make_num(32'h80000000, 5'd10, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'h80000000, 5'd8, 1'b1, 6'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'h7FFFFFFF, 5'd10, 1'b0, 6'd0, 1'b0, 1'b1, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'd123, 5'd10, 1'b0, 6'd8, 1'b1, 1'b0, 1'b1, 1'b0));
    pending_nums.push_back(make_num(32'hFFFFFFFF, 5'd10, 1'b0, 6'd63, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'd0, 5'd16, 1'b1, 6'd63, 1'b0, 1'b1, 1'b1, 1'b0));
    pending_nums.push_back(make_num(32'h12345678, 5'd0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'hCAFEF00D, 5'd31, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'd4095, 5'd7, 1'b0, 6'd3, 1'b1, 1'b0, 1'b1, 1'b0));
    pending_nums.push_back(make_num(32'hABCDEF01, 5'd17, 1'b1, 6'd12, 1'b0, 1'b0, 1'b0, 1'b1));
    pending_nums.push_back(make_num(32'd987654321, 5'd9, 1'b0, 6'd0, 1'b0, 1'b1, 1'b1, 1'b0));
    pending_nums.push_back(make_num(32'h0BADBEEF, 5'd12, 1'b1, 6'd5, 1'b1, 1'b0, 1'b0, 1'b1));
    pending_nums.push_back(make_num(32'hFFFFFF85, 5'd10, 1'b0, 6'd6, 1'b1, 1'b1, 1'b1, 1'b0));
    pending_nums.push_back(make_num(32'd42, 5'd10, 1'b1, 6'd4, 1'b0, 1'b1, 1'b1, 1'b0));
    pending_nums.push_back(make_num(32'd1234567, 5'd10, 1'b0, 6'd2, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'hDEADBEEF, 5'd16, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_nums.push_back(make_num(32'hDEADBEEF, 5'd16, 1'b1, 6'd10, 1'b1, 1'b0, 1'b0, 1'b1));
    pending_nums.push_back(make_num(32'd0, 5'd8, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    it = make_num(32'd7, 5'd15, 1'b0, 6'd33, 1'b0, 1'b1, 1'b0, 1'b1);
    it.wait_drain = 1'b1;
    pending_nums.push_back(it);

    // Random numbers, mostly common radices and short widths
    for (i = 0; i < RANDOM_NUMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        it.value = $urandom;
      end else if (pick < 65) begin
        it.value = $urandom_range(0, 999);
      end else if (pick < 80) begin
        it.value = -$urandom_range(1, 1000);
      end else if (pick < 90) begin
        it.value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
      end else begin
        case ($urandom_range(0, 3))
          0: it.value = 32'd0;
          1: it.value = 32'h7FFFFFFF;
          2: it.value = 32'h80000000;
          default: it.value = 32'hFFFFFFFF;
        endcase
      end
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 2))
          0: it.radix = 5'd8;
          1: it.radix = 5'd10;
          default: it.radix = 5'd16;
        endcase
      end else begin
        it.radix = itoa_pkg::RADIX_W'($urandom_range(0, 31));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        it.pad_width = itoa_pkg::PAD_W'($urandom_range(0, 12));
      end else if (pick < 90) begin
        it.pad_width = itoa_pkg::PAD_W'($urandom_range(13, 24));
      end else begin
        it.pad_width = itoa_pkg::PAD_W'($urandom_range(25, 63));
      end
      it.is_unsigned    = ($urandom_range(0, 99) < 40);
      it.pad_with_zeros = 1'($urandom_range(0, 1));
      it.force_plus     = 1'($urandom_range(0, 1));
      it.space_for_plus = 1'($urandom_range(0, 1));
      it.upper_case     = 1'($urandom_range(0, 1));
      it.wait_drain     = (i % 100 == 99);
      pending_nums.push_back(it);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for the last transfer, then for all text to come back
    while (pending_nums.size() != 0 || in_valid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers into %0d checked characters, longest text %0d.",
             nums_taken, chars_checked, longest_text);
    $display("Covered signed and unsigned modes, radices 0..31, pad widths up to 63.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
